// ----- rtl/cbt_pkg.sv -----
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared constants, payload types and record types of the cubic Bezier
// tessellator.
// ----------------------------------------------------------------------------
package cbt_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_W    = 32;
    localparam int PC_W       = 7;

    localparam logic [PC_W-1:0] PC_RESET = PC_W'(16);

    // span d = n - 1 and its powers
    localparam int D_W  = $clog2(MAX_POINTS);
    localparam int D2_W = 2 * D_W;
    localparam int D3_W = 3 * D_W;

    // numerator of a point offset: |N| < 2^COORD_W * d^3
    localparam int N_W   = COORD_W + D3_W + 1;
    localparam int MAG_W = N_W - 1;
    // quotient magnitude stays below 2^COORD_W (convex hull)
    localparam int Q_W   = COORD_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);

    // cycles the input holds off after a register write
    localparam int SETTLE_CYCLES = 3;
    localparam int SET_W         = $clog2(SETTLE_CYCLES + 1);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [N_W-1:0]     t_wide;

    typedef struct packed {
        t_coord p0_x;
        t_coord p0_y;
        t_coord p0_z;
        t_coord p1_x;
        t_coord p1_y;
        t_coord p1_z;
        t_coord p2_x;
        t_coord p2_y;
        t_coord p2_z;
        t_coord p3_x;
        t_coord p3_y;
        t_coord p3_z;
    } t_in_item;

    typedef struct packed {
        t_coord curve_x;
        t_coord curve_y;
        t_coord curve_z;
        logic   last_point;
    } t_out_item;

    // per axis start point and forward differences of the numerator
    typedef struct packed {
        t_coord p0;
        t_wide  d1;
        t_wide  d2;
        t_wide  d3;
    } t_axis_seed;

    typedef struct packed {
        t_axis_seed [2:0] ax;
    } t_seed;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        t_coord           p0;
    } t_lane_in;

    typedef struct packed {
        t_lane_in [2:0] lane;
        logic           last;
    } t_point;

    typedef struct packed {
        logic [D_W-1:0]  d;
        logic [D3_W-1:0] d3;
    } t_geom;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- rtl/cbt_front.sv -----
// ----------------------------------------------------------------------------
// cbt_front
// Holds the point count register, accepts control point sets and turns them
// into start points and forward differences of the curve numerator.
// ----------------------------------------------------------------------------
module cbt_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  cbt_pkg::t_in_item          i_in_data,
    input  logic                       i_cfg_valid,
    input  logic [cbt_pkg::PC_W-1:0]   i_cfg_data,
    output cbt_pkg::t_geom             o_geom,
    output logic                       o_push,
    output cbt_pkg::t_seed             o_seed,
    input  cbt_pkg::t_q_stat           i_q_stat
);

    logic [cbt_pkg::PC_W-1:0]  r_point_count;
    logic [cbt_pkg::D_W-1:0]   r_d, n_d;
    logic [cbt_pkg::D2_W-1:0]  r_d2;
    logic [cbt_pkg::D3_W-1:0]  r_d3;
    logic [cbt_pkg::SET_W-1:0] r_settle;

    logic r_v1, r_v2, r_v3;
    logic advance, accept;

    cbt_pkg::t_coord q0 [0:2];
    cbt_pkg::t_coord q1 [0:2];
    cbt_pkg::t_coord q2 [0:2];
    cbt_pkg::t_coord q3 [0:2];
    cbt_pkg::t_wide  n_a [0:2];
    cbt_pkg::t_wide  n_b [0:2];
    cbt_pkg::t_wide  n_c [0:2];

    cbt_pkg::t_wide  r1_a [0:2];
    cbt_pkg::t_wide  r1_b [0:2];
    cbt_pkg::t_wide  r1_c [0:2];
    cbt_pkg::t_coord r1_p0 [0:2];
    cbt_pkg::t_wide  r2_a [0:2];
    cbt_pkg::t_wide  r2_a6 [0:2];
    cbt_pkg::t_wide  r2_bd [0:2];
    cbt_pkg::t_wide  r2_cd2 [0:2];
    cbt_pkg::t_coord r2_p0 [0:2];
    cbt_pkg::t_seed  r3_seed;

    // clamp the count to 2 .. MAX_POINTS
    always_comb begin
        if (int'(r_point_count) < 2) begin
            n_d = cbt_pkg::D_W'(1);
        end else if (int'(r_point_count) > cbt_pkg::MAX_POINTS) begin
            n_d = cbt_pkg::D_W'(cbt_pkg::MAX_POINTS - 1);
        end else begin
            n_d = cbt_pkg::D_W'(r_point_count - cbt_pkg::PC_W'(1));
        end
    end

    assign advance    = !r_v3 || !i_q_stat.full;
    assign o_in_stall = !advance || (r_settle != '0);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_v3 && !i_q_stat.full;
    assign o_seed     = r3_seed;
    assign o_geom.d   = r_d;
    assign o_geom.d3  = r_d3;

    always_comb begin
        q0[0] = i_in_data.p0_x; q0[1] = i_in_data.p0_y; q0[2] = i_in_data.p0_z;
        q1[0] = i_in_data.p1_x; q1[1] = i_in_data.p1_y; q1[2] = i_in_data.p1_z;
        q2[0] = i_in_data.p2_x; q2[1] = i_in_data.p2_y; q2[2] = i_in_data.p2_z;
        q3[0] = i_in_data.p3_x; q3[1] = i_in_data.p3_y; q3[2] = i_in_data.p3_z;
        for (int ax = 0; ax < 3; ax++) begin
            n_c[ax] = 3 * (cbt_pkg::t_wide'(q1[ax]) - cbt_pkg::t_wide'(q0[ax]));
            n_b[ax] = 3 * (cbt_pkg::t_wide'(q2[ax]) - cbt_pkg::t_wide'(q1[ax])) - n_c[ax];
            n_a[ax] = cbt_pkg::t_wide'(q3[ax]) - cbt_pkg::t_wide'(q0[ax])
                      - n_c[ax] - n_b[ax];
        end
    end

    // register and derived span powers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= cbt_pkg::PC_RESET;
            r_settle      <= cbt_pkg::SET_W'(cbt_pkg::SETTLE_CYCLES);
        end else if (i_cfg_valid) begin
            r_point_count <= i_cfg_data;
            r_settle      <= cbt_pkg::SET_W'(cbt_pkg::SETTLE_CYCLES);
        end else if (r_settle != '0) begin
            r_settle <= r_settle - cbt_pkg::SET_W'(1);
        end
        r_d  <= n_d;
        r_d2 <= cbt_pkg::D2_W'(r_d) * cbt_pkg::D2_W'(r_d);
        r_d3 <= cbt_pkg::D3_W'(r_d2) * cbt_pkg::D3_W'(r_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (advance) begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int ax = 0; ax < 3; ax++) begin
                r1_a[ax]   <= n_a[ax];
                r1_b[ax]   <= n_b[ax];
                r1_c[ax]   <= n_c[ax];
                r1_p0[ax]  <= q0[ax];

                r2_a[ax]   <= r1_a[ax];
                r2_a6[ax]  <= (r1_a[ax] <<< 2) + (r1_a[ax] <<< 1);
                r2_bd[ax]  <= r1_b[ax] * $signed({1'b0, r_d});
                r2_cd2[ax] <= r1_c[ax] * $signed({1'b0, r_d2});
                r2_p0[ax]  <= r1_p0[ax];

                r3_seed.ax[ax].p0 <= r2_p0[ax];
                r3_seed.ax[ax].d1 <= r2_a[ax] + r2_bd[ax] + r2_cd2[ax];
                r3_seed.ax[ax].d2 <= r2_a6[ax] + (r2_bd[ax] <<< 1);
                r3_seed.ax[ax].d3 <= r2_a6[ax];
            end
        end
    end

endmodule

// ----- rtl/cbt_queue.sv -----
// ----------------------------------------------------------------------------
// cbt_queue
// Short first-in first-out queue of curve seeds between front and back.
// ----------------------------------------------------------------------------
module cbt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cbt_pkg::t_seed   i_data,
    input  logic             i_pop,
    output cbt_pkg::t_seed   o_data,
    output cbt_pkg::t_q_stat o_stat
);

    cbt_pkg::t_seed            r_mem [0:cbt_pkg::QUEUE_DEPTH-1];
    logic [cbt_pkg::QA_W-1:0]  r_wr, r_rd;
    logic [cbt_pkg::QA_W:0]    r_count;

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_count == (cbt_pkg::QA_W+1)'(cbt_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + cbt_pkg::QA_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + cbt_pkg::QA_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (cbt_pkg::QA_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (cbt_pkg::QA_W+1)'(1);
            end
        end
    end

endmodule

// ----- rtl/cbt_stepper.sv -----
// ----------------------------------------------------------------------------
// cbt_stepper
// Walks the curve by forward differencing of the exact numerator, one point
// per cycle while the divider advances.
// ----------------------------------------------------------------------------
module cbt_stepper (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [cbt_pkg::D_W-1:0] i_d,
    input  cbt_pkg::t_q_stat        i_q_stat,
    input  cbt_pkg::t_seed          i_q_data,
    output logic                    o_pop,
    input  logic                    i_adv,
    output logic                    o_point_valid,
    output cbt_pkg::t_point         o_point
);

    logic                    r_busy;
    logic [cbt_pkg::D_W-1:0] r_idx;
    cbt_pkg::t_wide          r_n  [0:2];
    cbt_pkg::t_wide          r_d1 [0:2];
    cbt_pkg::t_wide          r_d2 [0:2];
    cbt_pkg::t_wide          r_d3 [0:2];
    cbt_pkg::t_coord         r_p0 [0:2];
    logic                    emit, last, load;

    assign emit          = r_busy && i_adv;
    assign last          = (r_idx == i_d);
    assign load          = (!r_busy || (emit && last)) && !i_q_stat.empty;
    assign o_pop         = load;
    assign o_point_valid = emit;

    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            o_point.lane[ax].neg = r_n[ax][cbt_pkg::N_W-1];
            o_point.lane[ax].mag = r_n[ax][cbt_pkg::N_W-1]
                                   ? cbt_pkg::MAG_W'(-r_n[ax])
                                   : cbt_pkg::MAG_W'(r_n[ax]);
            o_point.lane[ax].p0  = r_p0[ax];
        end
        o_point.last = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
        end else if (emit && last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_idx <= '0;
            for (int ax = 0; ax < 3; ax++) begin
                r_n[ax]  <= '0;
                r_d1[ax] <= i_q_data.ax[ax].d1;
                r_d2[ax] <= i_q_data.ax[ax].d2;
                r_d3[ax] <= i_q_data.ax[ax].d3;
                r_p0[ax] <= i_q_data.ax[ax].p0;
            end
        end else if (emit) begin
            r_idx <= r_idx + cbt_pkg::D_W'(1);
            for (int ax = 0; ax < 3; ax++) begin
                r_n[ax]  <= r_n[ax] + r_d1[ax];
                r_d1[ax] <= r_d1[ax] + r_d2[ax];
                r_d2[ax] <= r_d2[ax] + r_d3[ax];
            end
        end
    end

endmodule

// ----- rtl/cbt_divider.sv -----
// ----------------------------------------------------------------------------
// cbt_divider
// Pipelined restoring divider, one quotient bit per stage and three lanes,
// then round half away from zero, add the start point and saturate.
// ----------------------------------------------------------------------------
module cbt_divider (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [cbt_pkg::D3_W-1:0] i_d3,
    input  logic                     i_valid,
    input  cbt_pkg::t_point          i_point,
    output logic                     o_adv,
    output logic                     o_out_valid,
    output cbt_pkg::t_out_item       o_out_data,
    input  logic                     i_out_stall
);

    logic                     r_v    [0:cbt_pkg::Q_W];
    logic                     r_last [0:cbt_pkg::Q_W];
    logic [cbt_pkg::D3_W-1:0] r_rem  [0:cbt_pkg::Q_W][0:2];
    logic [cbt_pkg::Q_W-1:0]  r_lo   [0:cbt_pkg::Q_W][0:2];
    logic [cbt_pkg::Q_W-1:0]  r_q    [0:cbt_pkg::Q_W][0:2];
    logic                     r_neg  [0:cbt_pkg::Q_W][0:2];
    cbt_pkg::t_coord          r_p0   [0:cbt_pkg::Q_W][0:2];

    logic [cbt_pkg::D3_W-1:0] n_rem  [1:cbt_pkg::Q_W][0:2];
    logic                     n_bit  [1:cbt_pkg::Q_W][0:2];
    cbt_pkg::t_coord          n_res  [0:2];

    logic                     r_out_valid;
    cbt_pkg::t_out_item       r_out;
    logic                     en;

    logic [cbt_pkg::D3_W:0]    trial;
    logic                      round_up;
    logic [cbt_pkg::Q_W:0]     qr;
    logic signed [cbt_pkg::COORD_W+1:0] val, sum;

    assign en          = !(r_out_valid && i_out_stall);
    assign o_adv       = en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // one quotient bit per stage
    always_comb begin
        for (int s = 1; s <= cbt_pkg::Q_W; s++) begin
            for (int l = 0; l < 3; l++) begin
                trial = {r_rem[s-1][l], r_lo[s-1][l][cbt_pkg::Q_W-1]};
                n_bit[s][l] = (trial >= {1'b0, i_d3});
                n_rem[s][l] = n_bit[s][l] ? cbt_pkg::D3_W'(trial - {1'b0, i_d3})
                                          : cbt_pkg::D3_W'(trial);
            end
        end
    end

    // round, restore sign, add start point, saturate
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            round_up = ({r_rem[cbt_pkg::Q_W][l], 1'b0} >= {1'b0, i_d3});
            qr  = {1'b0, r_q[cbt_pkg::Q_W][l]} + (cbt_pkg::Q_W+1)'(round_up);
            val = r_neg[cbt_pkg::Q_W][l] ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
            sum = $signed({{2{r_p0[cbt_pkg::Q_W][l][cbt_pkg::COORD_W-1]}},
                           r_p0[cbt_pkg::Q_W][l]}) + val;
            if ((&sum[cbt_pkg::COORD_W+1:cbt_pkg::COORD_W-1])
                || !(|sum[cbt_pkg::COORD_W+1:cbt_pkg::COORD_W-1])) begin
                n_res[l] = sum[cbt_pkg::COORD_W-1:0];
            end else if (sum[cbt_pkg::COORD_W+1]) begin
                n_res[l] = {1'b1, {(cbt_pkg::COORD_W-1){1'b0}}};
            end else begin
                n_res[l] = {1'b0, {(cbt_pkg::COORD_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= cbt_pkg::Q_W; s++) begin
                r_v[s] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= cbt_pkg::Q_W; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_out_valid <= r_v[cbt_pkg::Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_last[0] <= i_point.last;
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= i_point.lane[l].mag[cbt_pkg::MAG_W-1:cbt_pkg::Q_W];
                r_lo[0][l]  <= i_point.lane[l].mag[cbt_pkg::Q_W-1:0];
                r_q[0][l]   <= '0;
                r_neg[0][l] <= i_point.lane[l].neg;
                r_p0[0][l]  <= i_point.lane[l].p0;
            end
            for (int s = 1; s <= cbt_pkg::Q_W; s++) begin
                r_last[s] <= r_last[s-1];
                for (int l = 0; l < 3; l++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    r_lo[s][l]  <= {r_lo[s-1][l][cbt_pkg::Q_W-2:0], 1'b0};
                    r_q[s][l]   <= {r_q[s-1][l][cbt_pkg::Q_W-2:0], n_bit[s][l]};
                    r_neg[s][l] <= r_neg[s-1][l];
                    r_p0[s][l]  <= r_p0[s-1][l];
                end
            end
            r_out.curve_x    <= n_res[0];
            r_out.curve_y    <= n_res[1];
            r_out.curve_z    <= n_res[2];
            r_out.last_point <= r_last[cbt_pkg::Q_W];
        end
    end

endmodule

// ----- rtl/cubic_bezier_tessellator.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_tessellator
// Evaluates a cubic Bezier curve from four 3-D control points at point_count
// evenly spaced parameter values, exact to the rounded rational value.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  --------  ---------  -------------------------  ------------------------
//  input     in         i_in_valid / o_in_stall    i_in_data  (P0..P3)
//  output    out        o_out_valid / i_out_stall  o_out_data (point, last)
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (point_count)
//
//  One curve point leaves per cycle while the output is not stalled; a control
//  point set yields n points, n being point_count clamped to 2 .. MAX_POINTS,
//  from the stepper, which walks the curve one point per cycle while the
//  divider advances. Path: 3 front stages, the seed queue, the stepper, then
//  Q_W + 2 divider stages.
//  Reset is synchronous, active low; the register returns to 16 points.
//  After reset and after a register write the input stalls while the span
//  powers are recomputed. An output stall freezes the divider pipeline and
//  the stepper; the seed queue lets the front keep accepting sets meanwhile,
//  until the queue is full.
//
module cubic_bezier_tessellator (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  cbt_pkg::t_in_item        i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output cbt_pkg::t_out_item       o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [cbt_pkg::PC_W-1:0] i_cfg_data
);

    cbt_pkg::t_geom   geom;
    cbt_pkg::t_seed   push_seed, head_seed;
    cbt_pkg::t_q_stat q_stat;
    cbt_pkg::t_point  point;
    logic             push, pop, point_valid, adv;

    // the register is always writable; the block is idle by contract
    assign o_cfg_ready = 1'b1;

    // front: register, coefficients, forward-difference seeds
    cbt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg_valid(i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_geom     (geom),
        .o_push     (push),
        .o_seed     (push_seed),
        .i_q_stat   (q_stat)
    );

    // decouple front from back
    cbt_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_seed),
        .i_pop  (pop),
        .o_data (head_seed),
        .o_stat (q_stat)
    );

    // back: walk the curve, one numerator per point
    cbt_stepper u_stepper (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_d          (geom.d),
        .i_q_stat     (q_stat),
        .i_q_data     (head_seed),
        .o_pop        (pop),
        .i_adv        (adv),
        .o_point_valid(point_valid),
        .o_point      (point)
    );

    // back: divide by d^3, round, offset, saturate, hold the result
    cbt_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_d3       (geom.d3),
        .i_valid    (point_valid),
        .i_point    (point),
        .o_adv      (adv),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall)
    );

    // a register write must hold off new transactions while d powers settle
    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> o_in_stall)
        else $error("transaction accepted right after register write");

    // the stepper only takes a seed that is there
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("seed queue underflow");

    // the front never drops a seed into a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("seed queue overflow");

    // no result survives reset
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule
